// ----- sv/extent_free_list_block_allocator_macros.svh -----
`ifndef EXTENT_FREE_LIST_BLOCK_ALLOCATOR_MACROS_SVH
`define EXTENT_FREE_LIST_BLOCK_ALLOCATOR_MACROS_SVH

// Property holds at every clock edge outside reset.
`define EFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define EFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/efl_pkg.sv -----
`default_nettype none
package efl_pkg;

	localparam int OPCODE_W   = 2;
	localparam int VOL_W      = 3;
	localparam int BLK_W      = 12;
	localparam int STATUS_W   = 3;
	localparam int OCC_W      = 13;
	localparam int VBLK_W     = 13;
	localparam int VCNT_W     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 32;

	localparam logic [VCNT_W-1:0] MAX_VOLUMES = 4'd8;
	localparam logic [OCC_W-1:0]  OCC_MAX     = 13'h1FFF;

	typedef logic [OPCODE_W-1:0]  opcode_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam opcode_t OP_FORMAT  = 2'd0;
	localparam opcode_t OP_ALLOC   = 2'd1;
	localparam opcode_t OP_RELEASE = 2'd2;

	localparam status_t ST_OK            = 3'd0;
	localparam status_t ST_BAD_VOLUME    = 3'd1;
	localparam status_t ST_NOT_FORMATTED = 3'd2;
	localparam status_t ST_EMPTY         = 3'd3;
	localparam status_t ST_BAD_BLOCK     = 3'd4;

	localparam cfg_idx_t CFG_VOLUME_BLOCKS = 1'b0;
	localparam cfg_idx_t CFG_VOLUME_COUNT  = 1'b1;

endpackage
`default_nettype wire

// ----- sv/extent_free_list_block_allocator.sv -----
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    opcode, volume_index, block_number
// m_*      out  m_tvalid/m_tready    allocated_block, status, occupied_blocks
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each request reads the head run header from the header RAM in the accept
// cycle; S_EXEC modifies it and writes it back once the last response is taken.
// One request in flight; a new one is taken while a response waits on m_*.
// A response stalled on m_tready holds the next request in S_EXEC.
// Reset: not formatted, empty list, zero occupancy; header RAM is not cleared.
// cfg_ready is always high; write configuration only while idle.
`default_nettype none
module extent_free_list_block_allocator
	import efl_pkg::*;
#(
	parameter int MAX_BLOCKS = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // opcode, volume_index, block_number
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_TDATA_W-1:0]  m_tdata,   // allocated_block, status, occupied_blocks
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire cfg_idx_t              cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BW = $clog2(MAX_BLOCKS);
	localparam int M_USED_W = BLK_W + STATUS_W + OCC_W;

	logic [VBLK_W-1:0] volume_blocks_q;
	logic [VCNT_W-1:0] volume_count_q;

	logic              mem_we;
	logic [BW-1:0]     mem_waddr;
	logic [2*BW-1:0]   mem_wdata;
	logic              mem_re;
	logic [BW-1:0]     mem_raddr;
	logic [2*BW-1:0]   mem_rdata;
	logic [BLK_W-1:0]  rsp_block;
	status_t           rsp_status;
	logic [OCC_W-1:0]  rsp_occupied;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_blocks_q <= 13'd4096;
			volume_count_q  <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VOLUME_BLOCKS: volume_blocks_q <= cfg_data;
				CFG_VOLUME_COUNT:  volume_count_q  <= cfg_data[VCNT_W-1:0];
				default: ;
			endcase
		end
	end

	efl_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.BW(BW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (s_tvalid),
		.req_ready    (s_tready),
		.req_opcode   (s_tdata[OPCODE_W-1:0]),
		.req_volume   (s_tdata[OPCODE_W +: VOL_W]),
		.req_block    (s_tdata[OPCODE_W+VOL_W +: BLK_W]),
		.volume_blocks(volume_blocks_q),
		.volume_count (volume_count_q),
		.rsp_valid    (m_tvalid),
		.rsp_ready    (m_tready),
		.rsp_block    (rsp_block),
		.rsp_status   (rsp_status),
		.rsp_occupied (rsp_occupied),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	efl_hdr_ram #(
		.DEPTH(MAX_BLOCKS),
		.AW(BW),
		.DW(2*BW)
	) u_hdr_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign m_tdata = {{(M_TDATA_W-M_USED_W){1'b0}}, rsp_occupied, rsp_status, rsp_block};

endmodule
`default_nettype wire

// ----- sv/efl_hdr_ram.sv -----
`default_nettype none
module efl_hdr_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 24
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- sv/efl_ctrl.sv -----
`default_nettype none
module efl_ctrl
	import efl_pkg::*;
#(
	parameter int MAX_BLOCKS = 4096,
	parameter int BW         = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire opcode_t           req_opcode,
	input  wire logic [VOL_W-1:0]  req_volume,
	input  wire logic [BLK_W-1:0]  req_block,
	input  wire logic [VBLK_W-1:0] volume_blocks,
	input  wire logic [VCNT_W-1:0] volume_count,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [BLK_W-1:0]       rsp_block,
	output status_t                rsp_status,
	output logic [OCC_W-1:0]       rsp_occupied,
	output logic                   mem_we,
	output logic [BW-1:0]          mem_waddr,
	output logic [2*BW-1:0]        mem_wdata,
	output logic                   mem_re,
	output logic [BW-1:0]          mem_raddr,
	input  wire logic [2*BW-1:0]   mem_rdata
);

	localparam int SZ_W = (BW + 1 > VBLK_W) ? BW + 1 : VBLK_W;
	localparam logic [SZ_W-1:0] MAX_C = SZ_W'(MAX_BLOCKS);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t             state_q;
	opcode_t            op_q;
	logic [VOL_W-1:0]   vol_q;
	logic [BLK_W-1:0]   blk_q;
	logic [BW-1:0]      head_q;
	logic [OCC_W-1:0]   occ_q;
	logic               fmt_q;
	logic               rsp_valid_q;
	logic [BLK_W-1:0]   rsp_block_q;
	status_t            rsp_status_q;

	logic               finish;
	logic [VCNT_W-1:0]  vol_lim;
	logic               vol_ok;
	logic [SZ_W-1:0]    size;
	logic [SZ_W-1:0]    head_ext;
	logic [SZ_W-1:0]    head_inc;
	logic [SZ_W-1:0]    blk_ext;
	logic [BW-1:0]      run_len;
	logic [BW-1:0]      run_next;
	status_t            status_nx;
	logic [BLK_W-1:0]   given_nx;
	logic [BW-1:0]      head_nx;
	logic [OCC_W-1:0]   occ_nx;
	logic               fmt_nx;
	logic               wr_nx;

	assign req_ready = (state_q == S_IDLE);
	assign finish    = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign mem_re    = req_valid && req_ready;
	assign mem_raddr = head_q;
	assign mem_we    = finish && wr_nx;

	assign vol_lim  = (volume_count < MAX_VOLUMES) ? volume_count : MAX_VOLUMES;
	assign vol_ok   = {1'b0, vol_q} < vol_lim;
	assign size     = (SZ_W'(volume_blocks) < MAX_C) ? SZ_W'(volume_blocks) : MAX_C;
	assign head_ext = SZ_W'(head_q);
	assign head_inc = head_ext + SZ_W'(1);
	assign blk_ext  = SZ_W'(blk_q);
	assign run_len  = mem_rdata[2*BW-1:BW];
	assign run_next = mem_rdata[BW-1:0];

	always_comb begin
		status_nx = ST_OK;
		given_nx  = '0;
		head_nx   = head_q;
		occ_nx    = occ_q;
		fmt_nx    = fmt_q;
		wr_nx     = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		if (op_q == OP_FORMAT || op_q == OP_ALLOC || op_q == OP_RELEASE) begin
			if (!vol_ok) begin
				status_nx = ST_BAD_VOLUME;
			end else if (op_q == OP_FORMAT) begin
				fmt_nx = 1'b1;
				occ_nx = '0;
				if (size < SZ_W'(2)) begin
					head_nx = '0;
				end else begin
					head_nx   = BW'(1);
					wr_nx     = 1'b1;
					mem_waddr = BW'(1);
					mem_wdata = {BW'(size - SZ_W'(1)), BW'(0)};
				end
			end else if (!fmt_q) begin
				status_nx = ST_NOT_FORMATTED;
			end else if (op_q == OP_ALLOC) begin
				if (head_q == '0 || head_ext >= MAX_C) begin
					status_nx = ST_EMPTY;
				end else begin
					given_nx = BLK_W'(head_ext);
					if (run_len <= BW'(1) || head_inc >= MAX_C) begin
						head_nx = (SZ_W'(run_next) < MAX_C) ? run_next : '0;
					end else begin
						head_nx   = BW'(head_inc);
						wr_nx     = 1'b1;
						mem_waddr = BW'(head_inc);
						mem_wdata = {run_len - BW'(1), run_next};
					end
					if (occ_q != OCC_MAX) begin
						occ_nx = occ_q + OCC_W'(1);
					end
				end
			end else begin
				if (blk_q == '0 || blk_ext >= size) begin
					status_nx = ST_BAD_BLOCK;
				end else begin
					head_nx   = BW'(blk_ext);
					wr_nx     = 1'b1;
					mem_waddr = BW'(blk_ext);
					mem_wdata = {BW'(1), head_q};
					if (occ_q != '0) begin
						occ_nx = occ_q - OCC_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_FORMAT;
			vol_q        <= '0;
			blk_q        <= '0;
			head_q       <= '0;
			occ_q        <= '0;
			fmt_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_block_q  <= '0;
			rsp_status_q <= ST_OK;
		end else begin
			if (rsp_valid_q && rsp_ready && !finish) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req_opcode;
						vol_q   <= req_volume;
						blk_q   <= req_block;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						rsp_valid_q  <= 1'b1;
						rsp_block_q  <= given_nx;
						rsp_status_q <= status_nx;
						head_q       <= head_nx;
						occ_q        <= occ_nx;
						fmt_q        <= fmt_nx;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp_block    = rsp_block_q;
	assign rsp_status   = rsp_status_q;
	assign rsp_occupied = occ_q;

endmodule
`default_nettype wire

// ----- sv/efl_checker.sv -----
`default_nettype none
`include "extent_free_list_block_allocator_macros.svh"
module efl_checker
	import efl_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [M_TDATA_W-1:0]  m_tdata
);

	logic    s_acc;
	status_t m_status;

	assign s_acc    = s_tvalid && s_tready;
	assign m_status = m_tdata[BLK_W +: STATUS_W];

	`EFL_ASSERT_NEXT(a_one_in_flight, s_acc, !s_tready, "request accepted while busy")
	`EFL_ASSERT(a_status_range, !m_tvalid || m_status <= ST_BAD_BLOCK, "status out of range")
	`EFL_ASSERT(a_block_on_error, !m_tvalid || m_status == ST_OK || m_tdata[BLK_W-1:0] == '0, "block given on error")
	`EFL_ASSERT_NEXT(a_rsp_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled response changed")

endmodule

bind extent_free_list_block_allocator efl_checker u_efl_checker (.*);
`default_nettype wire
